[rtl/core/bound_ip_register_machine_core_defines.svh]
// assertion macros used by the checker file
`ifndef BOUND_IP_REGISTER_MACHINE_CORE_DEFINES_SVH
`define BOUND_IP_REGISTER_MACHINE_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define RBM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rbm_pkg.sv]
package rbm_pkg;

  // default sizes
  localparam int NUM_REGS_DEF   = 6;
  localparam int PROG_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF  = 64;

  // stream payload widths
  localparam int S_DATA_W = 104;
  localparam int S_USED_W = 98;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 144;
  localparam int M_USER_W = 2;
  localparam int PORT_WORD_W = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EXEC = 2'd0,
    ST_HALT = 2'd1,
    ST_BAD  = 2'd2,
    ST_ACK  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,  OP_ADDI = 4'd1,  OP_MULR = 4'd2,  OP_MULI = 4'd3,
    OP_BANR = 4'd4,  OP_BANI = 4'd5,  OP_BORR = 4'd6,  OP_BORI = 4'd7,
    OP_SETR = 4'd8,  OP_SETI = 4'd9,  OP_GTIR = 4'd10, OP_GTRI = 4'd11,
    OP_GTRR = 4'd12, OP_EQIR = 4'd13, OP_EQRI = 4'd14, OP_EQRR = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PC,
    S_DEC,
    S_EXEC,
    S_MUL,
    S_WC,
    S_WIP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] b;
    logic [7:0] a;
    op_t        op;
  } instr_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // bit 0: field A names a register, bit 1: field B names a register
  localparam logic [1:0] REG_USE [16] = '{
    2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1,
    2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd1, 2'd3
  };

endpackage

[rtl/core/rbm_regfile.sv]
module rbm_regfile #(
  parameter int NUM_REGS  = rbm_pkg::NUM_REGS_DEF,
  parameter int WORD_BITS = rbm_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rbm_pkg::mem_ctl_t           ctl,
  input  logic [$clog2(NUM_REGS)-1:0] rd_addr0,
  input  logic [$clog2(NUM_REGS)-1:0] rd_addr1,
  output logic [WORD_BITS-1:0]        rd_data0,
  output logic [WORD_BITS-1:0]        rd_data1,
  input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
  input  logic [WORD_BITS-1:0]        wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]  vld;

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data0 <= vld[rd_addr0] ? mem[rd_addr0] : '0;
      rd_data1 <= vld[rd_addr1] ? mem[rd_addr1] : '0;
    end
  end

endmodule

[rtl/core/rbm_imem.sv]
module rbm_imem #(
  parameter int PROG_DEPTH = rbm_pkg::PROG_DEPTH_DEF
) (
  input  logic                          clk,
  input  rbm_pkg::mem_ctl_t             ctl,
  input  logic [$clog2(PROG_DEPTH)-1:0] rd_addr,
  output rbm_pkg::instr_t               rd_data,
  input  logic [$clog2(PROG_DEPTH)-1:0] wr_addr,
  input  rbm_pkg::instr_t               wr_data
);

  rbm_pkg::instr_t mem [PROG_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/rbm_mul.sv]
module rbm_mul #(
  parameter int WORD_BITS = rbm_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  output logic                 done,
  output logic [WORD_BITS-1:0] p
);

  localparam int H  = (WORD_BITS + 1) / 2;
  localparam int FW = 2 * H;

  localparam logic [1:0] PH_LO     = 2'd0;
  localparam logic [1:0] PH_CROSS1 = 2'd1;
  localparam logic [1:0] PH_CROSS2 = 2'd2;
  localparam logic [1:0] PH_SUM    = 2'd3;

  logic [FW-1:0] xe, ye, pp, prod, acc;
  logic [H-1:0]  mx, my;
  logic [1:0]    ph;
  logic          busy;

  assign xe = FW'(x);
  assign ye = FW'(y);

  // low x low, then high x low, then low x high; high x high falls off the word
  assign mx = (ph == PH_CROSS1) ? xe[FW-1:H] : xe[H-1:0];
  assign my = (ph == PH_CROSS2) ? ye[FW-1:H] : ye[H-1:0];
  assign pp = mx * my;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= PH_LO;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        ph   <= PH_CROSS1;
      end else if (busy) begin
        ph <= ph + 2'd1;
        if (ph == PH_SUM) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((start && !busy) || (busy && ph != PH_SUM)) begin
      prod <= pp;
    end
    if (busy) begin
      if (ph == PH_CROSS1) begin
        acc <= prod;
      end else begin
        acc <= acc + (prod << H);
      end
    end
  end

  assign p = acc[WORD_BITS-1:0];

endmodule

[rtl/core/bound_ip_register_machine_core.sv]
// Six-register machine (NUM_REGS words of WORD_BITS bits) whose program
// counter is whichever register counter_register names, with a store of
// PROG_DEPTH 28-bit instructions. Every input transaction gives exactly one
// output transaction: tuser carries cmd in and status out. Loads and
// register writes are done in the idle state; a multiply makes a step longer.
// The step time is set by the chain through the two synchronous
// memories: read the counter from the register file, fetch from the
// instruction store, read the operands, compute, then write the destination
// and the incremented counter back through the single write port. Multiplies
// run on a half-word multiplier that works through its partial products. The
// input stage holds one transaction, so the next one is taken while the current
// one runs, and the output register holds a finished result while the machine
// goes on. The register file reads as zero after reset; the instruction store
// has no reset and a slot must be loaded before it is executed.
module bound_ip_register_machine_core #(
  parameter int NUM_REGS   = rbm_pkg::NUM_REGS_DEF,
  parameter int PROG_DEPTH = rbm_pkg::PROG_DEPTH_DEF,
  parameter int WORD_BITS  = rbm_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot[5:0], opcode[9:6], operand_a[17:10], operand_b[25:18],
  // operand_c[33:26], write_value[97:34], zero fill above
  input  logic [rbm_pkg::S_DATA_W-1:0]    s_tdata,
  // cmd[1:0]
  input  logic [rbm_pkg::S_USER_W-1:0]    s_tuser,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // executed_slot[5:0], dest_register[8:6], result_value[72:9],
  // next_counter[136:73], zero fill above
  output logic [rbm_pkg::M_DATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic [rbm_pkg::M_USER_W-1:0]    m_tuser
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int IW = $clog2(PROG_DEPTH);
  localparam logic [10:0] DEPTH_LIM = 11'(PROG_DEPTH);

  // configuration registers
  logic [2:0] counter_reg;
  logic [6:0] prog_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_reg <= '0;
      prog_len    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rbm_pkg::CFG_COUNTER) begin
        counter_reg <= cfg_data[2:0];
      end else if (cfg_index == rbm_pkg::CFG_LENGTH) begin
        prog_len <= cfg_data;
      end
    end
  end

  // single-entry input stage, freed as soon as the sequencer picks it up
  logic                            ib_valid;
  logic [rbm_pkg::S_USED_W-1:0]    ib_data;
  logic [rbm_pkg::S_USER_W-1:0]    ib_user;
  logic                            ib_take;

  assign s_tready = !ib_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ib_valid <= 1'b1;
    end else if (ib_take) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ib_data <= s_tdata[rbm_pkg::S_USED_W-1:0];
      ib_user <= s_tuser;
    end
  end

  rbm_pkg::cmd_t ib_cmd;
  logic [5:0]    ib_slot;
  logic [3:0]    ib_opcode;
  logic [7:0]    ib_a, ib_b, ib_c;
  logic [63:0]   ib_wv;

  assign ib_cmd    = rbm_pkg::cmd_t'(ib_user);
  assign ib_slot   = ib_data[5:0];
  assign ib_opcode = ib_data[9:6];
  assign ib_a      = ib_data[17:10];
  assign ib_b      = ib_data[25:18];
  assign ib_c      = ib_data[33:26];
  assign ib_wv     = ib_data[97:34];

  // memories and multiplier
  rbm_pkg::mem_ctl_t    rf_ctl, im_ctl;
  logic [RW-1:0]        rf_rd_addr0, rf_rd_addr1, rf_wr_addr;
  logic [WORD_BITS-1:0] rf_rd0, rf_rd1, rf_wr_data;
  logic [IW-1:0]        im_rd_addr, im_wr_addr;
  rbm_pkg::instr_t      ins, im_wr_data;
  logic                 mul_start, mul_done;
  logic [WORD_BITS-1:0] mul_p;

  rbm_regfile #(
    .NUM_REGS  (NUM_REGS),
    .WORD_BITS (WORD_BITS)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rf_ctl),
    .rd_addr0 (rf_rd_addr0),
    .rd_addr1 (rf_rd_addr1),
    .rd_data0 (rf_rd0),
    .rd_data1 (rf_rd1),
    .wr_addr  (rf_wr_addr),
    .wr_data  (rf_wr_data)
  );

  rbm_imem #(
    .PROG_DEPTH (PROG_DEPTH)
  ) u_imem (
    .clk     (clk),
    .ctl     (im_ctl),
    .rd_addr (im_rd_addr),
    .rd_data (ins),
    .wr_addr (im_wr_addr),
    .wr_data (im_wr_data)
  );

  // working registers of the current step
  rbm_pkg::state_t      state, state_next;
  logic [WORD_BITS-1:0] pc, val, nxt;

  // request checks
  logic load_bad, write_bad, ip_bad;
  assign load_bad  = 32'(ib_slot) >= 32'(PROG_DEPTH);
  assign write_bad = 32'(ib_slot) >= 32'(NUM_REGS);
  assign ip_bad    = 32'(counter_reg) >= 32'(NUM_REGS);

  // halt when the counter is at or past min(program length, store depth)
  logic [10:0] bound;
  logic        halt;
  assign bound = (11'(prog_len) < DEPTH_LIM) ? 11'(prog_len) : DEPTH_LIM;
  assign halt  = rf_rd0 >= WORD_BITS'(bound);

  // operand index checks on the fetched instruction
  logic [1:0] use_reg;
  logic       dec_bad, is_mul;
  assign use_reg = rbm_pkg::REG_USE[ins.op];
  assign dec_bad = (32'(ins.c) >= 32'(NUM_REGS))
                || (use_reg[0] && (32'(ins.a) >= 32'(NUM_REGS)))
                || (use_reg[1] && (32'(ins.b) >= 32'(NUM_REGS)));
  assign is_mul  = (ins.op == rbm_pkg::OP_MULR) || (ins.op == rbm_pkg::OP_MULI);

  // execute: register operands come straight from the read data registers
  logic [WORD_BITS-1:0] ia, ib, opb, alu_val;
  assign ia  = WORD_BITS'(ins.a);
  assign ib  = WORD_BITS'(ins.b);
  assign opb = use_reg[1] ? rf_rd1 : ib;

  always_comb begin
    case (ins.op)
      rbm_pkg::OP_ADDR: alu_val = rf_rd0 + rf_rd1;
      rbm_pkg::OP_ADDI: alu_val = rf_rd0 + ib;
      rbm_pkg::OP_BANR: alu_val = rf_rd0 & rf_rd1;
      rbm_pkg::OP_BANI: alu_val = rf_rd0 & ib;
      rbm_pkg::OP_BORR: alu_val = rf_rd0 | rf_rd1;
      rbm_pkg::OP_BORI: alu_val = rf_rd0 | ib;
      rbm_pkg::OP_SETR: alu_val = rf_rd0;
      rbm_pkg::OP_SETI: alu_val = ia;
      rbm_pkg::OP_GTIR: alu_val = WORD_BITS'(ia > rf_rd1);
      rbm_pkg::OP_GTRI: alu_val = WORD_BITS'(rf_rd0 > ib);
      rbm_pkg::OP_GTRR: alu_val = WORD_BITS'(rf_rd0 > rf_rd1);
      rbm_pkg::OP_EQIR: alu_val = WORD_BITS'(ia == rf_rd1);
      rbm_pkg::OP_EQRI: alu_val = WORD_BITS'(rf_rd0 == ib);
      rbm_pkg::OP_EQRR: alu_val = WORD_BITS'(rf_rd0 == rf_rd1);
      default:          alu_val = '0; // multiplies go through the multiplier
    endcase
  end

  rbm_mul #(
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (rf_rd0),
    .y     (opb),
    .done  (mul_done),
    .p     (mul_p)
  );

  // output register
  logic                 out_valid;
  rbm_pkg::status_t     out_status;
  logic [5:0]           out_slot;
  logic [2:0]           out_dest;
  logic [WORD_BITS-1:0] out_val, out_nxt;
  logic                 out_free;

  assign out_free = !out_valid || m_tready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbm_pkg::S_IDLE: begin
        if (ib_valid) begin
          if (ib_cmd == rbm_pkg::CMD_STEP && !ip_bad) begin
            state_next = rbm_pkg::S_PC;
          end else begin
            state_next = rbm_pkg::S_DONE;
          end
        end
      end
      rbm_pkg::S_PC:   state_next = halt ? rbm_pkg::S_DONE : rbm_pkg::S_DEC;
      rbm_pkg::S_DEC:  state_next = dec_bad ? rbm_pkg::S_DONE : rbm_pkg::S_EXEC;
      rbm_pkg::S_EXEC: state_next = is_mul ? rbm_pkg::S_MUL : rbm_pkg::S_WC;
      rbm_pkg::S_MUL: begin
        if (mul_done) begin
          state_next = rbm_pkg::S_WC;
        end
      end
      rbm_pkg::S_WC:   state_next = rbm_pkg::S_WIP;
      rbm_pkg::S_WIP:  state_next = rbm_pkg::S_DONE;
      rbm_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rbm_pkg::S_IDLE;
        end
      end
      default:         state_next = rbm_pkg::S_IDLE;
    endcase
  end

  // memory strobes and addresses
  always_comb begin
    rf_ctl      = '0;
    im_ctl      = '0;
    rf_rd_addr0 = RW'(ins.a);
    rf_rd_addr1 = RW'(ins.b);
    rf_wr_addr  = RW'(ins.c);
    rf_wr_data  = val;
    im_rd_addr  = rf_rd0[IW-1:0];
    im_wr_addr  = IW'(ib_slot);
    im_wr_data  = '{c: ib_c, b: ib_b, a: ib_a, op: rbm_pkg::op_t'(ib_opcode)};
    mul_start   = 1'b0;
    ib_take     = 1'b0;
    unique case (state)
      rbm_pkg::S_IDLE: begin
        ib_take = ib_valid;
        if (ib_valid) begin
          unique case (ib_cmd)
            rbm_pkg::CMD_LOAD: im_ctl.wr_en = !load_bad;
            rbm_pkg::CMD_WRITE: begin
              rf_ctl.wr_en = !write_bad;
              rf_wr_addr   = RW'(ib_slot);
              rf_wr_data   = WORD_BITS'(ib_wv);
            end
            rbm_pkg::CMD_STEP: begin
              rf_ctl.rd_en = !ip_bad;
              rf_rd_addr0  = RW'(counter_reg);
            end
            default: ;  // unused command, answered with a bad status
          endcase
        end
      end
      rbm_pkg::S_PC:   im_ctl.rd_en = !halt;
      rbm_pkg::S_DEC:  rf_ctl.rd_en = !dec_bad;
      rbm_pkg::S_EXEC: mul_start = is_mul;
      rbm_pkg::S_WC:   rf_ctl.wr_en = 1'b1;
      rbm_pkg::S_WIP: begin
        rf_ctl.wr_en = 1'b1;
        rf_wr_addr   = RW'(counter_reg);
        rf_wr_data   = nxt;
      end
      default: ;
    endcase
  end

  // status for a transaction that finishes in the idle state
  rbm_pkg::status_t idle_status;
  always_comb begin
    unique case (ib_cmd)
      rbm_pkg::CMD_LOAD:  idle_status = load_bad ? rbm_pkg::ST_BAD : rbm_pkg::ST_ACK;
      rbm_pkg::CMD_WRITE: idle_status = write_bad ? rbm_pkg::ST_BAD : rbm_pkg::ST_ACK;
      default:            idle_status = rbm_pkg::ST_BAD;
    endcase
  end

  // step datapath and the result it leaves behind
  rbm_pkg::status_t     res_status;
  logic [5:0]           res_slot;
  logic [2:0]           res_dest;
  logic [WORD_BITS-1:0] res_val, res_nxt;

  always_ff @(posedge clk) begin
    case (state)
      rbm_pkg::S_IDLE: begin
        res_status <= idle_status;
        res_slot   <= '0;
        res_dest   <= '0;
        res_val    <= '0;
        res_nxt    <= '0;
      end
      rbm_pkg::S_PC: begin
        pc <= rf_rd0;
        if (halt) begin
          res_status <= rbm_pkg::ST_HALT;
        end
      end
      rbm_pkg::S_DEC: begin
        if (dec_bad) begin
          res_status <= rbm_pkg::ST_BAD;
        end
      end
      rbm_pkg::S_EXEC: begin
        if (!is_mul) begin
          val <= alu_val;
        end
      end
      rbm_pkg::S_MUL: begin
        if (mul_done) begin
          val <= mul_p;
        end
      end
      rbm_pkg::S_WC: begin
        // the destination may be the counter register itself
        nxt <= ((ins.c == 8'(counter_reg)) ? val : pc) + WORD_BITS'(1);
      end
      rbm_pkg::S_WIP: begin
        res_status <= rbm_pkg::ST_EXEC;
        res_slot   <= pc[5:0];
        res_dest   <= ins.c[2:0];
        res_val    <= val;
        res_nxt    <= nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rbm_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbm_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_dest   <= res_dest;
      out_val    <= res_val;
      out_nxt    <= res_nxt;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'b0, rbm_pkg::PORT_WORD_W'(out_nxt),
                     rbm_pkg::PORT_WORD_W'(out_val), out_dest, out_slot};

endmodule

[rtl/core/rbm_checker.sv]
`include "bound_ip_register_machine_core_defines.svh"

module rbm_checker #(
  parameter int NUM_REGS = rbm_pkg::NUM_REGS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rbm_pkg::M_DATA_W-1:0] m_tdata,
  input logic [rbm_pkg::M_USER_W-1:0] m_tuser
);

  // a stalled result holds still
  `RBM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

  // anything but an executed step carries all-zero fields
  `RBM_ASSERT(a_zero_fields, clk, rst, m_tvalid && (m_tuser != rbm_pkg::ST_EXEC) |-> (m_tdata == '0), "nonzero fields on a non-executed result")

  // an executed step names a real destination register
  `RBM_ASSERT(a_dest_range, clk, rst, m_tvalid && (m_tuser == rbm_pkg::ST_EXEC) |-> (32'(m_tdata[8:6]) < 32'(NUM_REGS)), "destination register out of range")

  // the input stage holds a single transaction
  `RBM_ASSERT(a_one_deep, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken while the input stage is full")

  // reset leaves no result pending and the input open
  `RBM_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind bound_ip_register_machine_core rbm_checker #(.NUM_REGS(NUM_REGS)) u_rbm_checker (.*);
